// ===== hdl/tcgw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console glyph writer package
// Shared constants, operation codes and types of the glyph writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcgw_pkg;

  // Screen geometry.
  localparam int TEXT_COLUMNS = 80;
  localparam int TEXT_ROWS    = 60;
  localparam int LINE_BYTES   = 320;
  localparam int GLYPH_COUNT  = 128;
  localparam int WORD_BYTES   = 4;

  // Field widths.
  localparam int FUNC_W   = 2;
  localparam int CODE_W   = 7;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 7;
  localparam int OFFSET_W = 16;

  // Glyph stores are addressed by the full character code.
  localparam int STORE_DEPTH = 2 ** CODE_W;

  // Rows are counted in pixel-row pairs, so the row index steps by two.
  localparam int ROW_LIMIT = 2 * TEXT_ROWS;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_PRINT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CURSOR = 2'd2;

  // Special character codes.
  localparam logic [CODE_W-1:0] CODE_NULL    = 7'd0;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 7'd10;

  // One drawn character handed from the cursor logic to the output side.
  typedef struct packed {
    logic                emit;
    logic [OFFSET_W-1:0] base;
  } tcgw_job_t;

endpackage

// ===== hdl/tcgw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcgw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tcgw_glyph_store.sv =====
// ----------------------------------------------------------------------------
// Glyph store
// Top and bottom pixel words per character code, with per-entry valid bits
// so that entries never loaded since reset read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcgw_glyph_store
  import tcgw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load_en,
  input  logic              rd_en,
  input  logic [CODE_W-1:0] code,
  input  logic [WORD_W-1:0] top_in,
  input  logic [WORD_W-1:0] bottom_in,
  output logic [WORD_W-1:0] top_word,
  output logic [WORD_W-1:0] bottom_word
);

  logic [STORE_DEPTH-1:0] loaded;
  logic                   in_range;
  logic                   hit;
  logic [WORD_W-1:0]      top_raw;
  logic [WORD_W-1:0]      bottom_raw;

  assign in_range = 32'(code) < GLYPH_COUNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (load_en && in_range) begin
      loaded[code] <= 1'b1;
    end
  end

  // The hit flag follows the read data of the RAMs.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit <= loaded[code] && in_range;
    end
  end

  tcgw_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_top_ram (
    .clk  (clk),
    .we   (load_en && in_range),
    .waddr(code),
    .wdata(top_in),
    .re   (rd_en),
    .raddr(code),
    .rdata(top_raw)
  );

  tcgw_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_bottom_ram (
    .clk  (clk),
    .we   (load_en && in_range),
    .waddr(code),
    .wdata(bottom_in),
    .re   (rd_en),
    .raddr(code),
    .rdata(bottom_raw)
  );

  assign top_word    = hit ? top_raw : '0;
  assign bottom_word = hit ? bottom_raw : '0;

endmodule

// ===== hdl/tcgw_cursor.sv =====
// ----------------------------------------------------------------------------
// Cursor tracker
// Holds the cursor, decodes each accepted beat and forms the byte offset
// of a drawn character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcgw_cursor
  import tcgw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [FUNC_W-1:0] func,
  input  logic [CODE_W-1:0] char_code,
  input  logic [POS_W-1:0]  cursor_col_in,
  input  logic [POS_W-1:0]  cursor_row_in,
  output tcgw_job_t         job
);

  logic [POS_W-1:0] cursor_column;
  logic [POS_W-1:0] cursor_row;
  logic [POS_W-1:0] cursor_column_next;
  logic [POS_W-1:0] cursor_row_next;
  logic [POS_W-1:0] row_step;
  logic [POS_W-1:0] row_wrapped;
  logic [POS_W-1:0] col_step;
  logic [POS_W-1:0] set_col;
  logic [POS_W-1:0] set_row;
  logic             is_print;
  logic [31:0]      base_full;

  assign row_step    = cursor_row + POS_W'(2);
  assign row_wrapped = (32'(row_step) >= ROW_LIMIT) ? '0 : row_step;
  assign col_step    = cursor_column + POS_W'(1);

  assign set_col = (32'(cursor_col_in) >= TEXT_COLUMNS) ? POS_W'(TEXT_COLUMNS - 1)
                                                        : cursor_col_in;
  assign set_row = (32'({cursor_row_in[POS_W-1:1], 1'b0}) >= ROW_LIMIT)
                   ? POS_W'(ROW_LIMIT - 2) : {cursor_row_in[POS_W-1:1], 1'b0};

  assign is_print = (func == FUNC_PRINT) && (char_code != CODE_NULL)
                    && (char_code != CODE_NEWLINE);

  assign base_full = 32'(cursor_row) * 32'(LINE_BYTES)
                   + 32'(cursor_column) * 32'(WORD_BYTES);

  assign job.emit = accept && is_print;
  assign job.base = base_full[OFFSET_W-1:0];

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    case (func)
      FUNC_CURSOR: begin
        cursor_column_next = set_col;
        cursor_row_next    = set_row;
      end
      FUNC_PRINT: begin
        if (char_code == CODE_NEWLINE) begin
          cursor_column_next = '0;
          cursor_row_next    = row_wrapped;
        end else if (char_code != CODE_NULL) begin
          if (32'(col_step) >= TEXT_COLUMNS) begin
            cursor_column_next = '0;
            cursor_row_next    = row_wrapped;
          end else begin
            cursor_column_next = col_step;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule

// ===== hdl/tcgw_out.sv =====
// ----------------------------------------------------------------------------
// Output sequencer
// Turns one drawn character into a top beat and a bottom beat, with an
// output register and a second-beat holding register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcgw_out
  import tcgw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tcgw_job_t           job,
  input  logic [WORD_W-1:0]   top_word,
  input  logic [WORD_W-1:0]   bottom_word,
  input  logic                out_stall,
  output logic                busy,
  output logic                out_valid,
  output logic [OFFSET_W-1:0] mem_offset,
  output logic [WORD_W-1:0]   pixel_word,
  output logic                last
);

  logic                j_valid;
  logic [OFFSET_W-1:0] j_base;
  logic                b_valid;
  logic [OFFSET_W-1:0] b_offset;
  logic [WORD_W-1:0]   b_word;
  logic                o_free;
  logic                j_move;

  assign o_free = !out_valid || !out_stall;
  assign j_move = j_valid && o_free && !b_valid;
  assign busy   = j_valid && !j_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!busy) begin
        j_valid <= job.emit;
      end
      if (j_move) begin
        b_valid <= 1'b1;
      end else if (o_free) begin
        b_valid <= 1'b0;
      end
      if (o_free) begin
        out_valid <= b_valid || j_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && job.emit) begin
      j_base <= job.base;
    end
    if (j_move) begin
      b_offset <= j_base + OFFSET_W'(LINE_BYTES);
      b_word   <= bottom_word;
    end
    if (o_free) begin
      if (b_valid) begin
        mem_offset <= b_offset;
        pixel_word <= b_word;
        last       <= 1'b1;
      end else begin
        mem_offset <= j_base;
        pixel_word <= top_word;
        last       <= 1'b0;
      end
    end
  end

  // A held bottom beat always sits behind a top beat still on the port.
  a_bottom_behind_top: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (out_valid && !last))
    else $error("bottom beat held without a top beat on the port");

  // A taken top beat is followed at once by its bottom beat.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (out_valid && last))
    else $error("top beat not followed by its bottom beat");

  // The bottom beat lands one line below the top beat.
  a_pair_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=>
      (mem_offset == $past(mem_offset) + OFFSET_W'(LINE_BYTES)))
    else $error("bottom beat offset is not one line below the top beat");

endmodule

// ===== hdl/text_console_glyph_writer_top.sv =====
// ----------------------------------------------------------------------------
// Text console glyph writer
// A printed character's input beat is registered into the job stage, with
// its glyph read; its top beat then moves to the output register, and its
// bottom beat follows in the cycle after, with no output stall.
// Printed characters are limited by the single output port that carries two
// beats per character; other operations are taken whenever in_stall is low.
// Reset clears the cursor and marks every glyph as unloaded (reads as zero).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_glyph_writer_top
  import tcgw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [CODE_W-1:0]   char_code,
  input  logic [WORD_W-1:0]   glyph_top,
  input  logic [WORD_W-1:0]   glyph_bottom,
  input  logic [POS_W-1:0]    cursor_col_in,
  input  logic [POS_W-1:0]    cursor_row_in,
  // Output channel: one frame buffer word write per beat.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OFFSET_W-1:0] mem_offset,
  output logic [WORD_W-1:0]   pixel_word,
  output logic                last
);

  logic      accept;
  logic      busy;
  tcgw_job_t job;
  logic [WORD_W-1:0] top_word;
  logic [WORD_W-1:0] bottom_word;

  // The input side only waits when a drawn character is parked in the job
  // stage and cannot move on to the output register this cycle.
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  // The cursor is updated at the accepting edge, so the next beat always
  // sees the cursor left behind by this one.
  tcgw_cursor u_cursor (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .func         (func),
    .char_code    (char_code),
    .cursor_col_in(cursor_col_in),
    .cursor_row_in(cursor_row_in),
    .job          (job)
  );

  // Glyph words are written on a load beat and read on every accepted beat.
  // A load followed by a print of the same code sees the new glyph, since
  // the write lands at the load's own edge.
  tcgw_glyph_store u_store (
    .clk        (clk),
    .rst        (rst),
    .load_en    (accept && (func == FUNC_LOAD)),
    .rd_en      (accept),
    .code       (char_code),
    .top_in     (glyph_top),
    .bottom_in  (glyph_bottom),
    .top_word   (top_word),
    .bottom_word(bottom_word)
  );

  // The output sequencer turns each character into a top and bottom beat.
  tcgw_out u_out (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .top_word   (top_word),
    .bottom_word(bottom_word),
    .out_stall  (out_stall),
    .busy       (busy),
    .out_valid  (out_valid),
    .mem_offset (mem_offset),
    .pixel_word (pixel_word),
    .last       (last)
  );

endmodule

// ===== tb/tb_text_console_glyph_writer_top.sv =====
// ----------------------------------------------------------------------------
// Text console glyph writer testbench
// Sends print, load glyph and set cursor commands through the input channel
// and checks every frame buffer word write on the output channel. A
// scoreboard keeps its own copy of the cursor and of both glyph stores to
// predict each write. A short directed sequence hits the corners: wraps,
// saturation and ignored codes. A long random run follows with bursty input
// and a changing output stall pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_glyph_writer_top;
  import tcgw_pkg::*;

  // The fourth function code has no meaning; the block must drop it.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Cursor limits that a set cursor command saturates to.
  localparam bit [POS_W-1:0] LAST_COLUMN = POS_W'(TEXT_COLUMNS - 1);
  localparam bit [POS_W-1:0] LAST_ROW    = POS_W'(ROW_LIMIT - 2);

  localparam int RANDOM_COMMANDS = 1300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int REPORT_LIMIT    = 10;

  // One console command as it travels on the input channel.
  typedef struct {
    bit [FUNC_W-1:0] op;
    bit [CODE_W-1:0] code;
    bit [WORD_W-1:0] top_word;
    bit [WORD_W-1:0] bottom_word;
    bit [POS_W-1:0]  col;
    bit [POS_W-1:0]  row;
  } console_cmd_t;

  // One frame buffer word write as it leaves on the output channel.
  typedef struct {
    bit [OFFSET_W-1:0] offset;
    bit [WORD_W-1:0]   word;
    bit                is_bottom;
  } frame_write_t;

  // Scoreboard: tracks the console state and the writes still owed.
  class glyph_write_scoreboard;
    bit [POS_W-1:0]  column;
    bit [POS_W-1:0]  row;
    bit [WORD_W-1:0] top_glyphs[STORE_DEPTH];
    bit [WORD_W-1:0] bottom_glyphs[STORE_DEPTH];
    frame_write_t    expected_writes[$];
    int mismatches;
    int writes_checked;
    int prints;
    int newlines;
    int loads;
    int moves;
    int ignored;
    int line_advances;
    int screen_wraps;

    function new();
      column = '0;
      row    = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        top_glyphs[i]    = '0;
        bottom_glyphs[i] = '0;
      end
    endfunction

    // Start of the next text line; the bottom of the screen wraps to the top.
    function void next_line();
      column = '0;
      row    = row + 7'd2;
      line_advances++;
      if (row >= ROW_LIMIT) begin
        row = '0;
        screen_wraps++;
      end
    endfunction

    // Notes an accepted command. Returns 0 when the block should ignore it.
    function bit note_command(console_cmd_t c);
      bit [31:0]      base;
      bit [POS_W-1:0] even_row;
      frame_write_t   w;
      bit             effective;
      effective = 1'b1;
      if (c.op == FUNC_LOAD) begin
        loads++;
        if (c.code < GLYPH_COUNT) begin
          top_glyphs[c.code]    = c.top_word;
          bottom_glyphs[c.code] = c.bottom_word;
        end
      end else if (c.op == FUNC_CURSOR) begin
        moves++;
        even_row = {c.row[POS_W-1:1], 1'b0};
        column   = (c.col >= TEXT_COLUMNS) ? LAST_COLUMN : c.col;
        row      = (even_row >= ROW_LIMIT) ? LAST_ROW : even_row;
      end else if (c.op == FUNC_PRINT && c.code == CODE_NEWLINE) begin
        newlines++;
        next_line();
      end else if (c.op == FUNC_PRINT && c.code != CODE_NULL) begin
        prints++;
        base        = row * LINE_BYTES + column * WORD_BYTES;
        w.offset    = base[OFFSET_W-1:0];
        w.word      = (c.code < GLYPH_COUNT) ? top_glyphs[c.code] : '0;
        w.is_bottom = 1'b0;
        expected_writes.push_back(w);
        base        = base + LINE_BYTES;
        w.offset    = base[OFFSET_W-1:0];
        w.word      = (c.code < GLYPH_COUNT) ? bottom_glyphs[c.code] : '0;
        w.is_bottom = 1'b1;
        expected_writes.push_back(w);
        column = column + 7'd1;
        if (column >= TEXT_COLUMNS)
          next_line();
      end else begin
        ignored++;
        effective = 1'b0;
      end
      return effective;
    endfunction

    // Compares one accepted write beat with the oldest write still owed.
    function void check_write(logic [OFFSET_W-1:0] offset, logic [WORD_W-1:0] word,
                              logic is_bottom);
      frame_write_t w;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected write: offset %0d word %08h last %b",
                   $time, offset, word, is_bottom);
      end else begin
        w = expected_writes.pop_front();
        writes_checked++;
        if (offset !== w.offset || word !== w.word || is_bottom !== w.is_bottom) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] write mismatch: expected offset %0d word %08h last %b,",
                     $time, w.offset, w.word, w.is_bottom,
                     " got offset %0d word %08h last %b", offset, word, is_bottom);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [FUNC_W-1:0]   func;
  logic [CODE_W-1:0]   char_code;
  logic [WORD_W-1:0]   glyph_top;
  logic [WORD_W-1:0]   glyph_bottom;
  logic [POS_W-1:0]    cursor_col_in;
  logic [POS_W-1:0]    cursor_row_in;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OFFSET_W-1:0] mem_offset;
  logic [WORD_W-1:0]   pixel_word;
  logic                last;

  glyph_write_scoreboard board;
  int idle_cycles = 0;
  int rx_cycle = 0;

  text_console_glyph_writer_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Output side. A beat is taken at an edge where out_valid is high and our
  // stall is low; both are read as they stood just before the edge. The
  // stall pattern steps in turn through no stall at all, light random
  // stalls, a fixed two-in-five pattern, and heavy random stalls.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_write(mem_offset, pixel_word, last);
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 256) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((rx_cycle % 5) < 2);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Watchdog: a long stretch with no beat on either channel means the block
  // has hung, since the sender never idles for long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic console_cmd_t make_command(bit [FUNC_W-1:0] op, bit [CODE_W-1:0] code,
                                                bit [WORD_W-1:0] top_word,
                                                bit [WORD_W-1:0] bottom_word,
                                                bit [POS_W-1:0] col, bit [POS_W-1:0] row);
    console_cmd_t c;
    c.op          = op;
    c.code        = code;
    c.top_word    = top_word;
    c.bottom_word = bottom_word;
    c.col         = col;
    c.row         = row;
    return c;
  endfunction

  // Random command mix. Prints dominate so the cursor walks across lines
  // and wraps the screen; loads keep the glyph stores changing. Cursor
  // moves are either fully random (often off screen, so they saturate),
  // near the bottom right corner so a wrap follows soon, or on screen.
  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int pick;
    int flavor;
    pick   = $urandom_range(0, 99);
    flavor = $urandom_range(0, 99);
    c = make_command(FUNC_PRINT, CODE_W'($urandom_range(0, 127)), $urandom, $urandom,
                     POS_W'($urandom_range(0, 127)), POS_W'($urandom_range(0, 127)));
    if (pick < 62) begin
      if (flavor < 3)
        c.code = CODE_NULL;
      else if (flavor < 9)
        c.code = CODE_NEWLINE;
    end else if (pick < 82) begin
      c.op = FUNC_LOAD;
    end else if (pick < 96) begin
      c.op = FUNC_CURSOR;
      if (flavor >= 70) begin
        c.col = POS_W'($urandom_range(0, TEXT_COLUMNS - 1));
        c.row = POS_W'($urandom_range(0, ROW_LIMIT - 1));
      end else if (flavor >= 40) begin
        c.col = POS_W'($urandom_range(TEXT_COLUMNS - 8, TEXT_COLUMNS - 1));
        c.row = POS_W'($urandom_range(ROW_LIMIT - 4, ROW_LIMIT - 1));
      end
    end else begin
      c.op = FUNC_UNUSED;
    end
    return c;
  endfunction

  // Presents one command and holds it until the block takes the beat.
  // The stall is read just after the edge, so it is the value the block
  // had at that edge.
  task automatic send_command(console_cmd_t c);
    in_valid      <= 1'b1;
    func          <= c.op;
    char_code     <= c.code;
    glyph_top     <= c.top_word;
    glyph_bottom  <= c.bottom_word;
    cursor_col_in <= c.col;
    cursor_row_in <= c.row;
    do @(posedge clk); while (in_stall);
    void'(board.note_command(c));
  endtask

  // Sender gap. The payload carries junk while valid is low.
  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      in_valid      <= 1'b0;
      func          <= FUNC_W'($urandom_range(0, 3));
      char_code     <= CODE_W'($urandom_range(0, 127));
      glyph_top     <= $urandom;
      glyph_bottom  <= $urandom;
      cursor_col_in <= POS_W'($urandom_range(0, 127));
      cursor_row_in <= POS_W'($urandom_range(0, 127));
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    console_cmd_t c;
    int effective_count;
    int burst;

    board = new();
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    func          <= FUNC_PRINT;
    char_code     <= CODE_NULL;
    glyph_top     <= '0;
    glyph_bottom  <= '0;
    cursor_col_in <= '0;
    cursor_row_in <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A glyph printed before any load draws zero words.
    send_command(make_command(FUNC_PRINT, 7'd65, '0, '0, '0, '0));
    // Load glyphs with the extreme pixel words, including slot 0 which can
    // never be printed and the newline slot which must never draw.
    send_command(make_command(FUNC_LOAD, 7'd65, 32'hFFFF_FFFF, 32'h0000_0000, '0, '0));
    send_command(make_command(FUNC_LOAD, 7'd127, 32'h0000_0000, 32'hFFFF_FFFF, '0, '0));
    send_command(make_command(FUNC_LOAD, CODE_NULL, 32'h1234_5678, 32'h8765_4321, '0, '0));
    send_command(make_command(FUNC_LOAD, CODE_NEWLINE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0, '0));
    send_command(make_command(FUNC_PRINT, 7'd65, '0, '0, '0, '0));
    send_command(make_command(FUNC_PRINT, 7'd127, '0, '0, '0, '0));
    // The null code and the unused function code leave everything alone.
    send_command(make_command(FUNC_PRINT, CODE_NULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              7'd127, 7'd127));
    send_command(make_command(FUNC_UNUSED, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              7'd127, 7'd127));
    send_command(make_command(FUNC_PRINT, CODE_NEWLINE, '0, '0, '0, '0));
    // A cursor far off screen saturates to the last cell; printing there
    // gives the largest offsets and then wraps the whole screen.
    send_command(make_command(FUNC_CURSOR, '0, '0, '0, 7'd127, 7'd127));
    send_command(make_command(FUNC_PRINT, 7'd65, '0, '0, '0, '0));
    send_command(make_command(FUNC_PRINT, 7'd127, '0, '0, '0, '0));
    // An odd row is rounded down; printing in the last column wraps a line.
    send_command(make_command(FUNC_CURSOR, '0, '0, '0, 7'd79, 7'd5));
    send_command(make_command(FUNC_PRINT, 7'd65, '0, '0, '0, '0));
    // A newline on the bottom line goes back to the top.
    send_command(make_command(FUNC_CURSOR, '0, '0, '0, 7'd0, 7'd118));
    send_command(make_command(FUNC_PRINT, CODE_NEWLINE, '0, '0, '0, '0));
    send_command(make_command(FUNC_PRINT, 7'd127, '0, '0, '0, '0));
    // Rows and columns just at and just past the screen edge.
    send_command(make_command(FUNC_CURSOR, '0, '0, '0, 7'd0, 7'd119));
    send_command(make_command(FUNC_CURSOR, '0, '0, '0, 7'd80, 7'd120));
    send_command(make_command(FUNC_PRINT, 7'd127, '0, '0, '0, '0));
    // Reloading a glyph replaces both halves.
    send_command(make_command(FUNC_LOAD, 7'd65, 32'h0000_0000, 32'hFFFF_FFFF, '0, '0));
    send_command(make_command(FUNC_PRINT, 7'd65, '0, '0, '0, '0));
    send_command(make_command(FUNC_CURSOR, '0, '0, '0, 7'd0, 7'd0));

    // Random part in bursts. A quarter of the gaps are empty, so long runs
    // go by with the sender never idle.
    effective_count = 0;
    while (effective_count < RANDOM_COMMANDS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && effective_count < RANDOM_COMMANDS; i++) begin
        c = random_command();
        send_command(c);
        if (!(c.op == FUNC_UNUSED || (c.op == FUNC_PRINT && c.code == CODE_NULL)))
          effective_count++;
      end
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed write, then keep running for a drain period
    // so that a stray extra write would still be caught.
    while (board.expected_writes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.expected_writes.size() != 0) begin
      $display("%0d writes never arrived", board.expected_writes.size());
      board.mismatches += board.expected_writes.size();
    end

    $display("Ran %0d prints, %0d newlines, %0d glyph loads,",
             board.prints, board.newlines, board.loads,
             " %0d cursor moves, %0d ignored commands.", board.moves, board.ignored);
    $display("Checked %0d word writes across %0d line advances",
             board.writes_checked, board.line_advances,
             " and %0d screen wraps; %0d mismatches.",
             board.screen_wraps, board.mismatches);
    if (board.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
